/* design/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants for the streaming pattern matcher
// Input and result words, operation codes and counter limits.
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

  localparam int unsigned CFG_W   = 11;  // pattern length register
  localparam int unsigned PIDX_W  = 10;  // pattern index field
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LEN_W   = 13;  // holds any length up to 4096

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TEXT = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [PIDX_W-1:0] pattern_index;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic             is_total;
    logic [CNT_W-1:0] match_position;
    logic [CNT_W-1:0] match_count;
  } out_item_t;

endpackage

`default_nettype wire

/* design/streaming_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// streaming_pattern_matcher: exact byte pattern matcher over a text stream
// Bit-parallel naive matching with one partial-match bit per pattern byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one word: a pattern byte load, a text byte or an
//   end-of-text mark. out_valid/out_ready carry one result word: a match
//   report (start position and running count) or the end-of-text total.
//   cfg_we/cfg_wdata set the pattern length; write it only while idle.
// Flow: a word is captured in the input register; its result (if any) is
//   then registered in the output register, which drives out_valid and
//   out_data.
// Throughput: one word per cycle while results are taken. Each text byte is compared against every
//   stored pattern byte at once in a row of per-position comparators, so the
//   per-cycle figure does not depend on the pattern length.
// Reset: clears partial-match bits, text position, match count and the
//   pattern length (to one). Pattern bytes are not cleared; load them first.
// Stall: while out_ready is low and a result waits, the input register
//   holds and in_ready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_pattern_matcher
  import spm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire in_item_t         in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      out_item_t        out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Input register
  logic     s1_valid_r;
  in_item_t s1_data_r;

  // Match state
  logic [BYTE_W-1:0]      pat_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pm_r, pm_nxt;
  logic [MAX_PATTERN-1:0] last_mask_r, last_mask_nxt;
  logic [IDX_W-1:0]       len_m1_r, len_m1_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic              adv;
  logic              produce;
  logic              hit;
  logic [LEN_W-1:0]  eff_m1;
  logic [LEN_W-1:0]  cfg_ext;
  logic [CNT_W-1:0]  len_m1_ext;
  logic [CNT_W-1:0]  start_pos;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  pos_inc;
  logic [MAX_PATTERN-1:0] shifted;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the written length to 1..MAX_PATTERN and keep length-1
  assign cfg_ext = {{(LEN_W-CFG_W){1'b0}}, cfg_wdata};

  always_comb begin
    if (cfg_ext == '0) begin
      eff_m1 = '0;
    end else if (cfg_ext > LEN_W'(MAX_PATTERN)) begin
      eff_m1 = LEN_W'(MAX_PATTERN - 1);
    end else begin
      eff_m1 = cfg_ext - LEN_W'(1);
    end
    len_m1_nxt = eff_m1[IDX_W-1:0];
    for (int k = 0; k < MAX_PATTERN; k++) begin
      last_mask_nxt[k] = (eff_m1 == LEN_W'(k));
    end
  end

  // Per-position compare: bit k survives if bit k-1 did and byte k matches
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k == 0) begin
        shifted[k] = (pat_r[k] == s1_data_r.byte_value);
      end else begin
        shifted[k] = pm_r[k-1] && (pat_r[k] == s1_data_r.byte_value);
      end
    end
  end

  assign hit        = |(shifted & last_mask_r);
  assign len_m1_ext = CNT_W'(len_m1_r);
  assign start_pos  = (pos_r >= len_m1_ext) ? (pos_r - len_m1_ext) : '0;
  assign cnt_inc    = (cnt_r == CNT_MAX) ? cnt_r : (cnt_r + CNT_W'(1));
  assign pos_inc    = (pos_r == CNT_MAX) ? pos_r : (pos_r + CNT_W'(1));

  always_comb begin
    pm_nxt       = pm_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    produce      = 1'b0;
    out_data_nxt = out_data_r;
    case (s1_data_r.func)
      FUNC_TEXT: begin
        pm_nxt  = shifted;
        pos_nxt = pos_inc;
        if (hit) begin
          cnt_nxt                     = cnt_inc;
          produce                     = 1'b1;
          out_data_nxt.is_total       = 1'b0;
          out_data_nxt.match_position = start_pos;
          out_data_nxt.match_count    = cnt_inc;
        end
      end
      FUNC_END: begin
        pm_nxt                      = '0;
        pos_nxt                     = '0;
        cnt_nxt                     = '0;
        produce                     = 1'b1;
        out_data_nxt.is_total       = 1'b1;
        out_data_nxt.match_position = '0;
        out_data_nxt.match_count    = cnt_r;
      end
      default: begin
        // pattern loads are written below; unused code does nothing
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pm_r        <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      len_m1_r    <= '0;
      last_mask_r <= {{(MAX_PATTERN-1){1'b0}}, 1'b1};
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= produce;
        pm_r        <= pm_nxt;
        pos_r       <= pos_nxt;
        cnt_r       <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        len_m1_r    <= len_m1_nxt;
        last_mask_r <= last_mask_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (adv && produce) begin
      out_data_r <= out_data_nxt;
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (adv && (s1_data_r.func == FUNC_LOAD) &&
          ({{(LEN_W-PIDX_W){1'b0}}, s1_data_r.pattern_index} == LEN_W'(k))) begin
        pat_r[k] <= s1_data_r.byte_value;
      end
    end
  end

endmodule

`default_nettype wire

/* design/spm_checker.sv */
// ----------------------------------------------------------------------------
// spm_checker: port-level checks for the streaming pattern matcher
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_checker
  import spm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Drop any pending result on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_total_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_total |-> out_data.match_position == '0)
    else $error("total report with nonzero position");

  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_total |-> out_data.match_count != '0)
    else $error("match report with zero count");

  // Back-to-back match reports never count down
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.is_total &&
    $past(out_valid && out_ready && !out_data.is_total)
    |-> out_data.match_count >= $past(out_data.match_count))
    else $error("match count went backwards");

endmodule

bind streaming_pattern_matcher spm_checker u_spm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
